### sv/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
// Beat structs for both channels, the cell entry record and the shift-mode code.
// No dependencies.
package lkv_pkg;

    localparam int KeyW   = 32;
    localparam int ValW   = 32;
    localparam int CfgW   = 5;

    // capacity_limit after reset
    localparam logic [CfgW-1:0] LimitRst = 5'd16;

    // request mode codes
    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef struct packed {
        logic                   mode;
        logic signed [KeyW-1:0] key;
        logic signed [ValW-1:0] value;
    } in_beat_t;

    typedef struct packed {
        logic                   hit;
        logic signed [ValW-1:0] read_value;
        logic                   evicted;
    } out_beat_t;

    // one slot of the recency chain
    typedef struct packed {
        logic            valid;
        logic [KeyW-1:0] key;
        logic [ValW-1:0] value;
    } entry_t;

    // how the chain moves on one request
    typedef enum logic [1:0] {
        SHIFT_NONE,
        SHIFT_HIT,
        SHIFT_EVICT,
        SHIFT_FILL
    } shift_mode_t;

endpackage

### sv/lkv_cell.sv
// One recency position of the LRU chain: holds a valid bit, key and value.
// Compares the request key and takes its neighbor's entry when the chain shifts.
// Depends on lkv_pkg.
module lkv_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lkv_pkg::shift_mode_t        mode,
    input  logic [lkv_pkg::KeyW-1:0]    req_key,
    input  lkv_pkg::entry_t             prev_entry,
    input  logic                        match_in,
    input  logic [lkv_pkg::ValW-1:0]    rd_in,
    output lkv_pkg::entry_t             entry,
    output logic                        match,
    output logic                        match_out,
    output logic [lkv_pkg::ValW-1:0]    rd_out
);

    logic                     valid_reg;
    logic [lkv_pkg::KeyW-1:0] key_reg;
    logic [lkv_pkg::ValW-1:0] value_reg;
    logic                     shift;

    // compare against the request and fold into the match and read chains
    assign match     = valid_reg && (key_reg == req_key);
    assign match_out = match | match_in;
    assign rd_out    = rd_in | (match ? value_reg : '0);

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.value = value_reg;

    // decide whether this position takes its neighbor's entry
    always_comb begin
        case (mode)
            lkv_pkg::SHIFT_HIT:   shift = match_out;
            lkv_pkg::SHIFT_EVICT: shift = valid_reg;
            lkv_pkg::SHIFT_FILL:  shift = prev_entry.valid;
            default:              shift = 1'b0;
        endcase
    end

    // advance the valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift) begin
            valid_reg <= prev_entry.valid;
        end
    end

    // advance key and value
    always_ff @(posedge aclk) begin
        if (shift) begin
            key_reg   <= prev_entry.key;
            value_reg <= prev_entry.value;
        end
    end

endmodule

### sv/lru_key_value_cache_unit.sv
// Top level of the LRU key-value cache: request/result handshakes, limit register
// and the chain of lkv_cell positions ordered from most to least recent.
// Depends on lkv_pkg and lkv_cell.
//
// Usage:
//   s_valid/s_ready/s_data carry a request beat (mode: get or put, key, value).
//   m_valid/m_ready/m_data carry one result beat per request (hit, read_value,
//   evicted), in request order.
//   cfg_wr_en/cfg_wr_data write capacity_limit; write it only while idle.
// Timing:
//   A request beat is registered on acceptance and resolved once the result register
//   can take it: the parallel key compare, the match chain through the cells and
//   the chain shift all settle combinationally, and the result beat is registered
//   on resolution. One request per cycle is sustained while m_ready is high.
// Stall:
//   When m_ready is low the result register holds, the pending request waits,
//   and s_ready drops once the request register is also full.
// Reset:
//   aresetn (synchronous, active low) empties the cache, drops pending beats
//   and sets capacity_limit to 16.
module lru_key_value_cache_unit #(
    parameter int ENTRIES = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  lkv_pkg::in_beat_t            s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output lkv_pkg::out_beat_t           m_data,
    input  logic                         cfg_wr_en,
    input  logic [lkv_pkg::CfgW-1:0]     cfg_wr_data
);

    localparam int CntW = $clog2(ENTRIES + 1);
    localparam int CmpW = (CntW > lkv_pkg::CfgW) ? CntW : lkv_pkg::CfgW;

    logic                        req_valid_reg;
    lkv_pkg::in_beat_t           req_reg;
    logic                        m_valid_reg;
    lkv_pkg::out_beat_t          m_data_reg;
    lkv_pkg::out_beat_t          m_data_next;
    logic [CntW-1:0]             count_reg;
    logic [CntW-1:0]             count_next;
    logic [lkv_pkg::CfgW-1:0]    limit_reg;

    logic                        fire;
    logic                        is_put;
    logic                        any_hit;
    logic                        full;
    logic [CmpW-1:0]             lim_nz;
    logic [CmpW-1:0]             lim_eff;
    lkv_pkg::shift_mode_t        mode_sel;
    lkv_pkg::shift_mode_t        cell_mode;
    lkv_pkg::entry_t             new_entry;

    lkv_pkg::entry_t             cell_entry [ENTRIES];
    logic [ENTRIES-1:0]          cell_match;
    logic [ENTRIES-1:0]          cell_valid;
    logic [ENTRIES:0]            match_chain;
    logic [lkv_pkg::ValW-1:0]    rd_chain [ENTRIES+1];

    // resolve the held request when the result register can take it
    assign fire    = req_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !req_valid_reg || fire;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // effective limit: zero acts as one, saturate at ENTRIES
    assign lim_nz  = (limit_reg == '0) ? CmpW'(1) : CmpW'(limit_reg);
    assign lim_eff = (lim_nz > CmpW'(ENTRIES)) ? CmpW'(ENTRIES) : lim_nz;
    assign full    = CmpW'(count_reg) >= lim_eff;

    assign is_put  = (req_reg.mode == lkv_pkg::MODE_PUT);
    assign any_hit = match_chain[0];

    // pick how the chain moves
    always_comb begin
        if (any_hit) begin
            mode_sel = lkv_pkg::SHIFT_HIT;
        end else if (is_put) begin
            mode_sel = full ? lkv_pkg::SHIFT_EVICT : lkv_pkg::SHIFT_FILL;
        end else begin
            mode_sel = lkv_pkg::SHIFT_NONE;
        end
    end

    assign cell_mode = fire ? mode_sel : lkv_pkg::SHIFT_NONE;

    // entry that lands in the most recent position
    assign new_entry.valid = 1'b1;
    assign new_entry.key   = req_reg.key;
    assign new_entry.value = is_put ? req_reg.value : rd_chain[0];

    // build the result beat
    always_comb begin
        m_data_next.hit        = any_hit;
        m_data_next.read_value = (!is_put && any_hit) ? rd_chain[0] : '0;
        m_data_next.evicted    = is_put && !any_hit && full;
    end

    // grow occupancy on a fill that evicts nothing
    always_comb begin
        count_next = count_reg;
        if (fire && is_put && !any_hit && !full) begin
            count_next = count_reg + CntW'(1);
        end
    end

    // chain ends
    assign match_chain[ENTRIES] = 1'b0;
    assign rd_chain[ENTRIES]    = '0;

    // row of recency cells, position 0 is most recent
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        lkv_pkg::entry_t prev;

        if (i == 0) begin : g_head
            assign prev = new_entry;
        end else begin : g_body
            assign prev = cell_entry[i-1];
        end

        lkv_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .mode       (cell_mode),
            .req_key    (req_reg.key),
            .prev_entry (prev),
            .match_in   (match_chain[i+1]),
            .rd_in      (rd_chain[i+1]),
            .entry      (cell_entry[i]),
            .match      (cell_match[i]),
            .match_out  (match_chain[i]),
            .rd_out     (rd_chain[i])
        );

        assign cell_valid[i] = cell_entry[i].valid;
    end

    // hold the request beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            req_valid_reg <= 1'b1;
        end else if (fire) begin
            req_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
    end

    // hold the result beat until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= m_data_next;
        end
    end

    // occupancy and limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            limit_reg <= lkv_pkg::LimitRst;
        end else begin
            count_reg <= count_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

`ifndef SYNTHESIS
    // occupancy matches the number of valid cells
    a_count_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(cell_valid) == count_reg)
        else $error("occupancy differs from valid cell count");

    // at most one valid cell matches the request key
    a_single_match: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cell_match))
        else $error("key present in more than one cell");

    // an eviction keeps occupancy steady
    a_evict_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        (cell_mode == lkv_pkg::SHIFT_EVICT) |=> $stable(count_reg))
        else $error("occupancy moved on eviction");

    // a result beat follows each resolved request
    a_fire_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid_reg)
        else $error("resolved request produced no result beat");
`endif

endmodule

### tb/sv/lru_key_value_cache_unit_tb.sv
// Self-checking testbench for lru_key_value_cache_unit: directed table, then random get/put
// traffic over small key pools, checked beat by beat against an LRU cache predictor.
// Depends on lkv_pkg and the lru_key_value_cache_unit RTL.
module lru_key_value_cache_unit_tb;

    localparam int ENTRIES    = 16;
    localparam int POOL_MAX   = 24;
    localparam int PHASES     = 10;
    localparam int PHASE_LEN  = 100;
    localparam int LONG_HOLD  = 120;

    // plan row kinds and answer sources
    localparam logic ROW_REQ   = 1'b0;
    localparam logic ROW_CFG   = 1'b1;
    localparam logic ANS_MODEL = 1'b0;
    localparam logic ANS_FIXED = 1'b1;

    // common fixed answers: miss or unused, put on a present key, put that evicts
    localparam lkv_pkg::out_beat_t WANT_NONE  = '{1'b0, 32'h0, 1'b0};
    localparam lkv_pkg::out_beat_t WANT_UPD   = '{1'b1, 32'h0, 1'b0};
    localparam lkv_pkg::out_beat_t WANT_EVICT = '{1'b0, 32'h0, 1'b1};

    typedef struct packed {
        logic                     kind;
        logic [lkv_pkg::CfgW-1:0] limit;
        logic                     mode;
        logic [31:0]              key;
        logic [31:0]              value;
        logic                     source;
        lkv_pkg::out_beat_t       want;
    } plan_row_t;

    localparam int PLAN_LEN = 26;

    // directed part: fixed answers only where they are obvious
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        '{ROW_REQ, 5'd0,  lkv_pkg::MODE_GET, 32'h0000_0000, 32'h0000_0000, ANS_FIXED, WANT_NONE},
        '{ROW_REQ, 5'd0,  lkv_pkg::MODE_PUT, 32'h7fff_ffff, 32'h8000_0000, ANS_FIXED, WANT_NONE},
        '{ROW_REQ, 5'd0,  lkv_pkg::MODE_GET, 32'h7fff_ffff, 32'h0000_0000, ANS_FIXED,
            '{1'b1, 32'h8000_0000, 1'b0}},
        '{ROW_REQ, 5'd0,  lkv_pkg::MODE_PUT, 32'h8000_0000, 32'h7fff_ffff, ANS_FIXED, WANT_NONE},
        '{ROW_REQ, 5'd0,  lkv_pkg::MODE_GET, 32'h8000_0000, 32'h0000_0000, ANS_FIXED,
            '{1'b1, 32'h7fff_ffff, 1'b0}},
        '{ROW_REQ, 5'd0,  lkv_pkg::MODE_PUT, 32'h7fff_ffff, 32'hffff_ffff, ANS_FIXED, WANT_UPD},
        '{ROW_REQ, 5'd0,  lkv_pkg::MODE_GET, 32'h7fff_ffff, 32'h1234_5678, ANS_FIXED,
            '{1'b1, 32'hffff_ffff, 1'b0}},
        '{ROW_REQ, 5'd0,  lkv_pkg::MODE_GET, 32'h0000_0000, 32'hffff_ffff, ANS_FIXED, WANT_NONE},
        '{ROW_REQ, 5'd0,  lkv_pkg::MODE_PUT, 32'hffff_ffff, 32'h0000_0000, ANS_FIXED, WANT_NONE},
        // a limit of zero behaves as one
        '{ROW_CFG, 5'd0,  lkv_pkg::MODE_GET, 32'h0,         32'h0,         ANS_MODEL, WANT_NONE},
        '{ROW_REQ, 5'd0,  lkv_pkg::MODE_PUT, 32'h0000_0001, 32'h0000_0001, ANS_FIXED, WANT_EVICT},
        '{ROW_REQ, 5'd0,  lkv_pkg::MODE_PUT, 32'h0000_0002, 32'h0000_0002, ANS_FIXED, WANT_EVICT},
        '{ROW_REQ, 5'd0,  lkv_pkg::MODE_GET, 32'h0000_0001, 32'h0000_0000, ANS_MODEL, WANT_NONE},
        '{ROW_REQ, 5'd0,  lkv_pkg::MODE_GET, 32'h7fff_ffff, 32'h0000_0000, ANS_MODEL, WANT_NONE},
        // a limit above the entry count saturates
        '{ROW_CFG, 5'd31, lkv_pkg::MODE_GET, 32'h0,         32'h0,         ANS_MODEL, WANT_NONE},
        '{ROW_REQ, 5'd0,  lkv_pkg::MODE_PUT, 32'h0000_0003, 32'h0000_0003, ANS_MODEL, WANT_NONE},
        '{ROW_REQ, 5'd0,  lkv_pkg::MODE_PUT, 32'h0000_0004, 32'h0000_0004, ANS_MODEL, WANT_NONE},
        '{ROW_REQ, 5'd0,  lkv_pkg::MODE_GET, 32'h0000_0002, 32'h0000_0000, ANS_MODEL, WANT_NONE},
        // lower the limit below the occupancy: puts evict one each
        '{ROW_CFG, 5'd2,  lkv_pkg::MODE_GET, 32'h0,         32'h0,         ANS_MODEL, WANT_NONE},
        '{ROW_REQ, 5'd0,  lkv_pkg::MODE_PUT, 32'h0000_0005, 32'h0000_0005, ANS_MODEL, WANT_NONE},
        '{ROW_REQ, 5'd0,  lkv_pkg::MODE_GET, 32'hffff_ffff, 32'h0000_0000, ANS_MODEL, WANT_NONE},
        '{ROW_REQ, 5'd0,  lkv_pkg::MODE_GET, 32'h0000_0004, 32'h0000_0000, ANS_MODEL, WANT_NONE},
        '{ROW_REQ, 5'd0,  lkv_pkg::MODE_PUT, 32'h0000_0006, 32'h0000_0006, ANS_MODEL, WANT_NONE},
        '{ROW_CFG, 5'd16, lkv_pkg::MODE_GET, 32'h0,         32'h0,         ANS_MODEL, WANT_NONE},
        '{ROW_REQ, 5'd0,  lkv_pkg::MODE_GET, 32'h0000_0001, 32'h0000_0000, ANS_MODEL, WANT_NONE},
        '{ROW_REQ, 5'd0,  lkv_pkg::MODE_PUT, 32'h0000_0002, 32'h8000_0001, ANS_MODEL, WANT_NONE}
    };

    // limits walked by the random phases: extremes and a drop below occupancy
    localparam logic [lkv_pkg::CfgW-1:0] PHASE_LIMIT [PHASES] = '{
        5'd16, 5'd31, 5'd1, 5'd4, 5'd0, 5'd8, 5'd16, 5'd2, 5'd12, 5'd16
    };

    logic                     aclk;
    logic                     aresetn     = 1'b0;
    logic                     s_valid     = 1'b0;
    logic                     s_ready;
    lkv_pkg::in_beat_t        s_data      = '0;
    logic                     m_valid;
    logic                     m_ready     = 1'b0;
    lkv_pkg::out_beat_t       m_data;
    logic                     cfg_wr_en   = 1'b0;
    logic [lkv_pkg::CfgW-1:0] cfg_wr_data = '0;

    lru_key_value_cache_unit #(
        .ENTRIES(ENTRIES)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop in case the handshakes hang
    initial begin
        #2_000_000;
        $display("[lru_key_value_cache_unit] ERROR");
        $finish;
    end

    // predictor state: slots plus recency list, most recent first
    logic [31:0]              slot_key [ENTRIES];
    logic [31:0]              slot_val [ENTRIES];
    bit                       slot_used [ENTRIES];
    int                       recency [ENTRIES];
    int                       fill_count = 0;
    logic [lkv_pkg::CfgW-1:0] limit_reg  = lkv_pkg::LimitRst;

    lkv_pkg::out_beat_t       answer_q [$];
    int unsigned              mismatches = 0;
    int unsigned              beats_sent = 0;

    // apply one request to the predicted cache and return its result beat
    function automatic lkv_pkg::out_beat_t cache_access(lkv_pkg::in_beat_t req);
        lkv_pkg::out_beat_t ans;
        int                 pos;
        int                 slot;
        int                 lim;
        ans  = '0;
        pos  = -1;
        slot = -1;
        for (int p = 0; p < ENTRIES; p++) begin
            if (pos < 0 && p < fill_count && slot_used[recency[p]] &&
                slot_key[recency[p]] == req.key)
                pos = p;
        end
        if (pos >= 0) begin
            slot    = recency[pos];
            ans.hit = 1'b1;
            if (req.mode == lkv_pkg::MODE_GET) ans.read_value = slot_val[slot];
            else slot_val[slot] = req.value;
            for (int p = pos; p > 0; p--) recency[p] = recency[p - 1];
            recency[0] = slot;
        end else if (req.mode == lkv_pkg::MODE_PUT) begin
            lim = (limit_reg == 0) ? 1 : (limit_reg > ENTRIES) ? ENTRIES : int'(limit_reg);
            // drop the least recent entry when at or over the limit
            if (fill_count >= lim) begin
                slot_used[recency[fill_count - 1]] = 1'b0;
                fill_count--;
                ans.evicted = 1'b1;
            end
            for (int s = ENTRIES - 1; s >= 0; s--) begin
                if (!slot_used[s]) slot = s;
            end
            for (int p = fill_count; p > 0; p--) recency[p] = recency[p - 1];
            recency[0]      = slot;
            slot_key[slot]  = req.key;
            slot_val[slot]  = req.value;
            slot_used[slot] = 1'b1;
            fill_count++;
        end
        return ans;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("mismatch on %s: got %h, want %h (%0d pending)",
                 what, got, want, answer_q.size());
    endtask

    // compare one result beat with the oldest pending answer
    task automatic check_result(lkv_pkg::out_beat_t got);
        lkv_pkg::out_beat_t want;
        if (answer_q.size() == 0) begin
            report_mismatch("unexpected beat", got.read_value, 32'h0);
        end else begin
            want = answer_q.pop_front();
            if (got.hit !== want.hit) report_mismatch("hit", 32'(got.hit), 32'(want.hit));
            if (got.read_value !== want.read_value)
                report_mismatch("read_value", got.read_value, want.read_value);
            if (got.evicted !== want.evicted)
                report_mismatch("evicted", 32'(got.evicted), 32'(want.evicted));
        end
    endtask

    // hold valid low for a random run of cycles, heavier in the sender-idle phase
    task automatic sender_idle();
        int unsigned pct;
        int unsigned gap;
        pct = (beats_sent < 340) ? 28 : (beats_sent < 680) ? 74 : 0;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // offer one request beat, then predict its answer once accepted
    task automatic send_request(lkv_pkg::in_beat_t req, logic source,
                                lkv_pkg::out_beat_t fixed_ans);
        lkv_pkg::out_beat_t ans;
        sender_idle();
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        ans = cache_access(req);
        answer_q.push_back(source == ANS_FIXED ? fixed_ans : ans);
    endtask

    // drain the block, then write capacity_limit
    task automatic write_limit(logic [lkv_pkg::CfgW-1:0] lim);
        s_valid <= 1'b0;
        while (answer_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lim;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        limit_reg = lim;
    endtask

    // result side: random back-pressure plus one long hold-off
    initial begin : result_sink
        int unsigned seen;
        int unsigned hold_left;
        int unsigned pct;
        seen      = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                check_result(m_data);
                seen++;
                if (seen == 400) hold_left = LONG_HOLD;
            end
            pct = (seen < 340) ? 74 : (seen < 680) ? 28 : 0;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= pct);
            end
        end
    end

    // request side: reset, directed table, random phases, drain
    initial begin : request_source
        lkv_pkg::in_beat_t req;
        logic [31:0]       key_pool [POOL_MAX];
        int unsigned       pool_n;
        int unsigned       lim_eff;
        for (int s = 0; s < ENTRIES; s++) begin
            slot_used[s] = 1'b0;
            recency[s]   = 0;
        end
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hffff_ffff;
        key_pool[2] = 32'h7fff_ffff;
        key_pool[3] = 32'h8000_0000;
        key_pool[4] = 32'h0000_0001;
        for (int i = 5; i < POOL_MAX; i++) key_pool[i] = $urandom;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // walk the directed table
        for (int r = 0; r < PLAN_LEN; r++) begin
            if (PLAN[r].kind == ROW_CFG) begin
                write_limit(PLAN[r].limit);
            end else begin
                req.mode  = PLAN[r].mode;
                req.key   = PLAN[r].key;
                req.value = PLAN[r].value;
                send_request(req, PLAN[r].source, PLAN[r].want);
            end
        end

        // random phases: keys mostly from a pool a little larger than the limit
        for (int ph = 0; ph < PHASES; ph++) begin
            write_limit(PHASE_LIMIT[ph]);
            lim_eff = (PHASE_LIMIT[ph] == 0) ? 1 :
                      (PHASE_LIMIT[ph] > ENTRIES) ? ENTRIES : PHASE_LIMIT[ph];
            pool_n  = lim_eff + $urandom_range(1, 8);
            if (pool_n > POOL_MAX) pool_n = POOL_MAX;
            for (int i = 0; i < PHASE_LEN; i++) begin
                req.mode  = $urandom_range(1) ? lkv_pkg::MODE_PUT : lkv_pkg::MODE_GET;
                req.key   = ($urandom_range(99) < 8) ? $urandom
                                                     : key_pool[$urandom_range(pool_n - 1)];
                req.value = $urandom;
                send_request(req, ANS_MODEL, WANT_NONE);
            end
        end

        // wait for the last beats and for any strays, then report
        s_valid <= 1'b0;
        while (answer_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[lru_key_value_cache_unit] OK");
        end else begin
            $display("[lru_key_value_cache_unit] ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
sv/lkv_pkg.sv
sv/lkv_cell.sv
sv/lru_key_value_cache_unit.sv
tb/sv/lru_key_value_cache_unit_tb.sv
